// ===== hw/rtl/spq_pkg.sv =====
//------------------------------------------------------------------------------
// spq_pkg: shared types and codes of the sorted priority queue
// Operation and status codes, controller states, control and status bundles.
//------------------------------------------------------------------------------
`default_nettype none
package spq_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT     = 2'd0,
        OP_REMOVE     = 2'd1,
        OP_FIND_MAX   = 2'd2,
        OP_DELETE_MAX = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_MAXRD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;      // capture request, clear scan pointer
        logic scan_step; // read next entry during search
        logic shift_step;// move one entry during shift
        logic max_rd;    // read top entry
        logic finish;    // commit and strobe result
    } ctrl_t;

    typedef struct packed {
        logic    scan_done;
        logic    shift_done;
        logic    is_full;
        logic    is_empty;
        op_t     op;
    } stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sorted_priority_queue_core.sv =====
//------------------------------------------------------------------------------
// sorted_priority_queue_core: sorted multiset with insert, remove and max ops
// Sequencer plus a RAM-backed sorted store searched and shifted per entry.
//------------------------------------------------------------------------------
// channel  | ports                          | transfer
// request  | start, busy, op, value         | start && !busy at clk edge
// result   | done, status, max_value,       | done high for one cycle
//          | entry_count                    |
//
// One request at a time. For insert and remove, a linear search reads one
// RAM word a cycle up to the stop point, then entries from there shift one
// word a cycle through the RAM's single write port. Max ops and a dropped
// insert skip the search and shift.
// done rises in the same cycle that busy falls.
// Reset clears the count, the read-valid flag and the sequencer state;
// store contents need no clearing.
// The result cannot be stalled: done marks one cycle of valid result.
//------------------------------------------------------------------------------
`default_nettype none
module sorted_priority_queue_core #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         op,
    input  wire logic signed [31:0] value,
    output logic                    done,
    output logic [1:0]              status,
    output logic signed [31:0]      max_value,
    output logic [6:0]              entry_count
);
    import spq_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    // sequencer: steps each request through search, shift and commit
    spq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .ctrl(ctrl), .stat(stat)
    );

    // store and compare logic
    spq_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
        .op(op), .value(value), .status(status), .max_value(max_value),
        .entry_count(entry_count)
    );

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> entry_count <= 7'(CAPACITY)) else $error("count overflow");
    a_max_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> max_value == '0) else $error("bad max");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/spq_ram.sv =====
//------------------------------------------------------------------------------
// spq_ram: generic single-port write, single-port read RAM
// One write and one registered read per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module spq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/spq_datapath.sv =====
//------------------------------------------------------------------------------
// spq_datapath: store, pointers and compare logic
// Searches the sorted store one entry a cycle and shifts entries one a cycle.
//------------------------------------------------------------------------------
`default_nettype none
module spq_datapath #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire spq_pkg::ctrl_t               ctrl,
    output spq_pkg::stat_t                    stat,
    input  wire logic [1:0]                   op,
    input  wire logic signed [31:0]           value,
    output logic [1:0]                        status,
    output logic signed [31:0]                max_value,
    output logic [6:0]                        entry_count
);
    import spq_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    op_t              op_reg;
    logic [31:0]      val_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    ptr_reg;      // scan index / shift index
    logic [CW-1:0]    pos_reg;      // target position
    logic             found_reg;
    logic             rd_vld_reg;   // rdata holds entry ptr_reg-1
    logic [1:0]       status_reg;
    logic [31:0]      maxv_reg;
    logic [COUNT_W-1:0] cnt_out_reg;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [31:0]      wdata, rdata;
    logic             hit_stop;
    logic [CW-1:0]    top;

    spq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // insert stops at first entry not below value; remove at first equal
    always_comb
    begin
        if (op_reg == OP_INSERT)
        begin
            hit_stop = !((rdata ^ 32'h8000_0000) < (val_reg ^ 32'h8000_0000));
        end
        else
        begin
            hit_stop = (rdata == val_reg);
        end
    end

    assign top = count_reg - CW'(1);

    always_comb
    begin
        we    = 1'b0;
        waddr = ptr_reg[AW-1:0];
        wdata = rdata;
        raddr = ptr_reg[AW-1:0];
        if (ctrl.max_rd)
        begin
            raddr = top[AW-1:0];
        end
        if (ctrl.scan_step && stat.scan_done && op_reg == OP_INSERT)
        begin
            // fetch the top entry for the first move of the shift
            raddr = top[AW-1:0];
        end
        if (ctrl.shift_step)
        begin
            if (op_reg == OP_INSERT)
            begin
                // walk down from top: write ptr from rdata of ptr-1
                raddr = ptr_reg[AW-1:0] - AW'(2);
                if (ptr_reg == pos_reg)
                begin
                    we    = 1'b1;
                    wdata = val_reg;
                end
                else
                begin
                    we = rd_vld_reg;
                end
            end
            else
            begin
                // walk up: write ptr-2 from rdata of ptr-1
                waddr = ptr_reg[AW-1:0] - AW'(2);
                we    = rd_vld_reg && (ptr_reg < count_reg + CW'(1));
            end
        end
    end

    assign stat.scan_done  = rd_vld_reg && (hit_stop || ptr_reg > count_reg)
                             || (!rd_vld_reg && count_reg == '0 && ctrl.scan_step)
                             || (rd_vld_reg && ptr_reg == count_reg + CW'(1));
    assign stat.shift_done = (op_reg == OP_INSERT) ? (ptr_reg == pos_reg && ctrl.shift_step)
                             : (ptr_reg >= count_reg + CW'(1) && rd_vld_reg);
    assign stat.is_full    = (count_reg == CW'(CAPACITY));
    assign stat.is_empty   = (count_reg == '0);
    assign stat.op         = op_reg;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.finish)
        begin
            unique case (op_reg)
                OP_INSERT:     count_next = stat.is_full ? count_reg : count_reg + CW'(1);
                OP_REMOVE:     count_next = found_reg ? count_reg - CW'(1) : count_reg;
                OP_FIND_MAX:   count_next = count_reg;
                OP_DELETE_MAX: count_next = stat.is_empty ? count_reg : count_reg - CW'(1);
                default:       count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_vld_reg <= ctrl.scan_step || ctrl.shift_step;
            if (ctrl.load || ctrl.finish)
            begin
                rd_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            op_reg    <= op_t'(op);
            val_reg   <= value;
            ptr_reg   <= '0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else if (ctrl.scan_step)
        begin
            if (stat.scan_done)
            begin
                // position of stop, or count if none
                if (rd_vld_reg && hit_stop && ptr_reg <= count_reg)
                begin
                    pos_reg   <= ptr_reg - CW'(1);
                    found_reg <= 1'b1;
                end
                else
                begin
                    pos_reg   <= count_reg;
                    found_reg <= 1'b0;
                end
                ptr_reg <= '0;
            end
            else
            begin
                ptr_reg <= ptr_reg + CW'(1);
            end
        end
        else if (ctrl.shift_step)
        begin
            if (op_reg == OP_INSERT)
            begin
                ptr_reg <= ptr_reg - CW'(1);
            end
            else
            begin
                ptr_reg <= ptr_reg + CW'(1);
            end
        end
        else if (ctrl.max_rd)
        begin
            // hold the read address on the top entry until commit
            ptr_reg <= top;
        end
        // set up shift start after scan
        if (ctrl.scan_step && stat.scan_done)
        begin
            if (op_reg == OP_INSERT)
            begin
                ptr_reg <= count_reg;
            end
            else
            begin
                ptr_reg <= ((rd_vld_reg && hit_stop && ptr_reg <= count_reg)
                            ? ptr_reg : count_reg) + CW'(1);
            end
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            maxv_reg <= '0;
            unique case (op_reg)
                OP_INSERT:
                begin
                    status_reg <= stat.is_full ? ST_FULL : ST_OK;
                end
                OP_REMOVE:
                begin
                    status_reg <= found_reg ? ST_OK : ST_ABSENT;
                end
                OP_FIND_MAX, OP_DELETE_MAX:
                begin
                    status_reg <= stat.is_empty ? ST_EMPTY : ST_OK;
                    maxv_reg   <= stat.is_empty ? '0 : rdata;
                end
                default:
                begin
                    status_reg <= ST_OK;
                end
            endcase
            cnt_out_reg <= COUNT_W'(count_next);
        end
    end

    assign status      = status_reg;
    assign max_value   = maxv_reg;
    assign entry_count = cnt_out_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/spq_ctrl.sv =====
//------------------------------------------------------------------------------
// spq_ctrl: operation sequencer
// Steps search, shift and max read, then strobes the result.
//------------------------------------------------------------------------------
`default_nettype none
module spq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    output logic                 done,
    output spq_pkg::ctrl_t       ctrl,
    input  wire spq_pkg::stat_t  stat
);
    import spq_pkg::*;

    state_t state_reg, state_next;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ctrl.finish;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (stat.op == OP_FIND_MAX || stat.op == OP_DELETE_MAX)
                begin
                    ctrl.max_rd = 1'b1;
                    state_next  = S_MAXRD;
                end
                else if (stat.op == OP_INSERT && stat.is_full)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.scan_step = 1'b1;
                    if (stat.scan_done)
                    begin
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                ctrl.shift_step = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_MAXRD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                ctrl.finish = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |-> state_reg == S_IDLE) else $error("load outside idle");
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |=> done) else $error("missing strobe");
    a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
`endif
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
//------------------------------------------------------------------------------
// tb: self-checking bench for sorted_priority_queue_core
// Drives insert, remove and max requests, keeps a sorted shadow multiset,
// and compares every result transfer against the predicted status, max and
// entry count.
//------------------------------------------------------------------------------
`default_nettype none
module tb;
    import spq_pkg::*;

    localparam int unsigned DEPTH = 64;

    typedef struct {
        op_t               op;
        logic signed [31:0] value;
    } request_t;

    typedef struct {
        status_t            status;
        logic signed [31:0] max_value;
        logic [6:0]         entry_count;
    } answer_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         op;
    logic signed [31:0] value;
    logic               done;
    logic [1:0]         status;
    logic signed [31:0] max_value;
    logic [6:0]         entry_count;

    sorted_priority_queue_core #(.CAPACITY(DEPTH)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .value      (value),
        .done       (done),
        .status     (status),
        .max_value  (max_value),
        .entry_count(entry_count)
    );

    // Shadow of the store: ascending signed values, one per held entry.
    logic signed [31:0] shadow_set[$];
    request_t           pending_requests[$];
    answer_t            expected_answers[$];
    int                 mismatch_count = 0;
    int                 gap_left = 0;

    // Random-phase insert values, picked again to aim removes at held entries.
    logic signed [31:0] shadow_pick[$];

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Update the shadow set with one accepted request and return its result.
    function automatic answer_t apply_request(request_t r);
        answer_t a;
        int      pos;
        a.status    = ST_OK;
        a.max_value = '0;
        case (r.op)
            OP_INSERT:
            begin
                if (shadow_set.size() >= DEPTH)
                    a.status = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < shadow_set.size() && shadow_set[pos] < r.value)
                        pos++;
                    shadow_set.insert(pos, r.value);
                end
            end
            OP_REMOVE:
            begin
                pos = -1;
                foreach (shadow_set[i])
                    if (pos < 0 && shadow_set[i] == r.value)
                        pos = i;
                if (pos < 0)
                    a.status = ST_ABSENT;
                else
                    shadow_set.delete(pos);
            end
            default:
            begin
                if (shadow_set.size() == 0)
                    a.status = ST_EMPTY;
                else
                begin
                    a.max_value = shadow_set[$];
                    if (r.op == OP_DELETE_MAX)
                        shadow_set.delete(shadow_set.size() - 1);
                end
            end
        endcase
        a.entry_count = 7'(shadow_set.size());
        return a;
    endfunction

    // Driver: hold requests until taken; fold in the next or wait a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            op       <= OP_INSERT;
            value    <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_answers.insert(expected_answers.size(),
                                        apply_request('{op_t'(op), value}));
                // Fold the next request in without lowering start in between.
                if (pending_requests.size() > 0 && $urandom_range(0, 3) == 0)
                begin
                    op    <= pending_requests[0].op;
                    value <= pending_requests[0].value;
                    pending_requests.delete(0);
                end
                else
                begin
                    start    <= 1'b0;
                    gap_left <= $urandom_range(0, 3);
                end
            end
            else if (!start)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending_requests.size() > 0)
                begin
                    start <= 1'b1;
                    op    <= pending_requests[0].op;
                    value <= pending_requests[0].value;
                    pending_requests.delete(0);
                end
            end
        end
    end

    // Monitor: every done cycle is one result transfer.
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status=%0d max=%0d count=%0d",
                             status, max_value, entry_count);
            end
            else
            begin
                e = expected_answers[0];
                expected_answers.delete(0);
                if (status !== e.status || max_value !== e.max_value
                    || entry_count !== e.entry_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp st=%0d max=%0d cnt=%0d,",
                                  " got st=%0d max=%0d cnt=%0d"},
                                 e.status, e.max_value, e.entry_count,
                                 status, max_value, entry_count);
                end
            end
        end
    end

    task automatic add_request(op_t o, logic signed [31:0] v);
        request_t r;
        r.op    = o;
        r.value = v;
        pending_requests.insert(pending_requests.size(), r);
    endtask

    // Pick a value: often one already held so removes hit, else a
    // narrow range to make duplicates, else full 32-bit noise.
    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && shadow_pick.size() > 0)
            return shadow_pick[$urandom_range(0, shadow_pick.size() - 1)];
        else if (sel < 7)
            return $signed($urandom_range(0, 15)) - 8;
        else
            return $urandom;
    endfunction

    initial
    begin
        int                 n;
        int                 bias;
        logic signed [31:0] v;
        rst_n = 1'b0;

        // Directed: empty-store max ops, absent remove, extremes, duplicates.
        add_request(OP_FIND_MAX, 32'sd0);
        add_request(OP_DELETE_MAX, 32'sd0);
        add_request(OP_REMOVE, 32'sd5);
        add_request(OP_INSERT, 32'sh8000_0000);
        add_request(OP_INSERT, 32'sh7FFF_FFFF);
        add_request(OP_INSERT, 32'sd0);
        add_request(OP_INSERT, -32'sd1);
        add_request(OP_INSERT, 32'sd7);
        add_request(OP_INSERT, 32'sd7);
        add_request(OP_FIND_MAX, 32'sd0);
        add_request(OP_DELETE_MAX, 32'sd0);
        add_request(OP_REMOVE, 32'sd7);
        add_request(OP_REMOVE, 32'sd7);
        add_request(OP_REMOVE, 32'sd7);
        add_request(OP_REMOVE, 32'sh8000_0000);
        add_request(OP_DELETE_MAX, 32'sd0);
        add_request(OP_DELETE_MAX, 32'sd0);
        add_request(OP_DELETE_MAX, 32'sd0);
        add_request(OP_FIND_MAX, 32'sd0);
        // Fill past capacity to hit the dropped-insert case, then drain.
        for (int i = 0; i < DEPTH + 2; i++)
            add_request(OP_INSERT, $urandom);
        for (int i = 0; i < DEPTH + 1; i++)
            add_request(OP_DELETE_MAX, 32'sd0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Random phases: alternate insert-heavy and delete-heavy bias so the
        // count sweeps between empty and full.
        n = 0;
        while (n < 900)
        begin
            bias = (n / 150) % 2 ? 25 : 75;
            for (int k = 0; k < 50; k++)
            begin
                v = pick_value();
                if ($urandom_range(0, 99) < bias)
                begin
                    add_request(OP_INSERT, v);
                    shadow_pick.insert(shadow_pick.size(), v);
                end
                else
                    add_request(op_t'($urandom_range(1, 3)), v);
                n++;
            end
            wait (pending_requests.size() == 0);
        end

        wait (pending_requests.size() == 0 && !start && expected_answers.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_answers.size() == 0)
            $display("PASS sorted_priority_queue_core");
        else
            $display("FAIL sorted_priority_queue_core");
        $finish;
    end

    // Watchdog: fails the run if it has not finished by the time limit.
    initial
    begin
        #2_000_000;
        $display("FAIL sorted_priority_queue_core");
        $finish;
    end
endmodule
`default_nettype wire
